// ===== design/cbt_pkg.sv =====
// Shared types and constants for the compacting binding table.
package cbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int ACT_W  = 3;
    localparam int CODE_W = 16;
    localparam int ID_W   = 8;

    localparam logic [CODE_W-1:0] EMPTY_CODE = 16'hFFFF;

    localparam logic [ACT_W-1:0] ACT_ADD        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CLR_ID     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLR_CODE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CODE_OF_ID = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ID_OF_CODE = 3'd4;

    // What the datapath does with an entry once its read data is back
    typedef enum logic [2:0] {
        MODE_MOVE,
        MODE_CLR_ID,
        MODE_CLR_CODE,
        MODE_FIND_ID,
        MODE_FIND_CODE,
        MODE_TAIL
    } mode_t;

    typedef struct packed {
        logic  load;       // latch operands, restart counters
        logic  miss_init;  // answer starts at -1 (lookups)
        logic  rd_en;      // read entry at read pointer, advance it
        mode_t mode;       // processing applied to that read
        logic  init_wr;    // reset clearing pass: empty entry at read pointer
        logic  put;        // append pair at write pointer, or flag drop
    } cmd_t;

    typedef struct packed {
        logic rd_last;     // read pointer on the last entry
        logic wr_full;     // write pointer past the last entry
        logic wr_last;     // write pointer on the last entry
    } status_t;

endpackage

// ===== design/cbt_ctrl.sv =====
// Sequencer for the binding table: reset clearing pass, sweeps, append, tail cleanup.
module cbt_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cbt_pkg::ACT_W-1:0]     action,
    input  cbt_pkg::status_t              status,
    output cbt_pkg::cmd_t                 cmd,
    output logic                          busy,
    output logic                          done
);
    import cbt_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_PUT,
        S_TAIL,
        S_TDRAIN
    } state_t;

    state_t             state_reg, state_next;
    logic [ACT_W-1:0]   action_reg, action_next;
    logic               done_reg, done_next;
    mode_t              sweep_mode;

    always_comb
    begin
        unique case (action_reg)
            ACT_ADD:        sweep_mode = MODE_MOVE;
            ACT_CLR_ID:     sweep_mode = MODE_CLR_ID;
            ACT_CLR_CODE:   sweep_mode = MODE_CLR_CODE;
            ACT_CODE_OF_ID: sweep_mode = MODE_FIND_ID;
            ACT_ID_OF_CODE: sweep_mode = MODE_FIND_CODE;
            default:        sweep_mode = MODE_MOVE;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        action_next   = action_reg;
        done_next     = 1'b0;
        cmd           = '0;
        cmd.mode      = MODE_MOVE;

        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (status.rd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load      = 1'b1;
                    cmd.miss_init = (action == ACT_CODE_OF_ID) || (action == ACT_ID_OF_CODE);
                    action_next   = action;
                    if (action <= ACT_ID_OF_CODE)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        // unused codes: no table work, zero result right away
                        done_next = 1'b1;
                    end
                end
            end
            S_SWEEP:
            begin
                cmd.rd_en = 1'b1;
                cmd.mode  = sweep_mode;
                if (status.rd_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (action_reg == ACT_ADD)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_PUT:
            begin
                cmd.put = 1'b1;
                if (status.wr_full || status.wr_last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                cmd.rd_en = 1'b1;
                cmd.mode  = MODE_TAIL;
                if (status.rd_last)
                begin
                    state_next = S_TDRAIN;
                end
            end
            S_TDRAIN:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            action_reg <= ACT_ADD;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            action_reg <= action_next;
            done_reg   <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== design/cbt_datapath.sv =====
// Table memory, read/write pointers, operand and result registers of the binding table.
module cbt_datapath
#(
    parameter int TABLE_ENTRIES = cbt_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cbt_pkg::cmd_t                     cmd,
    input  logic signed [cbt_pkg::CODE_W-1:0] key_code,
    input  logic [cbt_pkg::ID_W-1:0]          binding_id,
    output cbt_pkg::status_t                  status,
    output logic signed [cbt_pkg::CODE_W-1:0] answer,
    output logic                              dropped
);
    import cbt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] FULL_IDX = CW'(TABLE_ENTRIES);

    logic [CODE_W-1:0] code_mem [TABLE_ENTRIES];
    logic [ID_W-1:0]   id_mem   [TABLE_ENTRIES];

    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [CW-1:0]     wr_idx_reg, wr_idx_next;
    logic              pipe_valid_reg;
    mode_t             pipe_mode_reg;
    logic [AW-1:0]     pipe_addr_reg;
    logic [CODE_W-1:0] code_q_reg;
    logic [ID_W-1:0]   id_q_reg;
    logic [CODE_W-1:0] op_code_reg;
    logic [ID_W-1:0]   op_id_reg;
    logic [CODE_W-1:0] answer_reg, answer_next;
    logic              found_reg, found_next;
    logic              dropped_reg, dropped_next;

    logic              we;
    logic [AW-1:0]     wa;
    logic [CODE_W-1:0] wcode;
    logic [ID_W-1:0]   wid;
    logic              q_used;

    assign q_used = (code_q_reg != EMPTY_CODE);

    always_comb
    begin
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        answer_next  = answer_reg;
        found_next   = found_reg;
        dropped_next = dropped_reg;
        we           = 1'b0;
        wa           = pipe_addr_reg;
        wcode        = EMPTY_CODE;
        wid          = '0;

        if (cmd.load)
        begin
            rd_idx_next  = '0;
            wr_idx_next  = '0;
            found_next   = 1'b0;
            dropped_next = 1'b0;
            answer_next  = cmd.miss_init ? EMPTY_CODE : '0;
        end

        if (cmd.init_wr)
        begin
            we          = 1'b1;
            wa          = rd_idx_reg[AW-1:0];
            rd_idx_next = rd_idx_reg + CW'(1);
        end

        if (cmd.rd_en)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end

        if (cmd.put)
        begin
            if (wr_idx_reg == FULL_IDX)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                we          = 1'b1;
                wa          = wr_idx_reg[AW-1:0];
                wcode       = op_code_reg;
                wid         = op_id_reg;
                // tail cleanup starts just past the appended pair
                rd_idx_next = wr_idx_reg + CW'(1);
            end
        end

        if (pipe_valid_reg)
        begin
            case (pipe_mode_reg)
                MODE_MOVE:
                begin
                    if (q_used)
                    begin
                        if (wr_idx_reg[AW-1:0] != pipe_addr_reg)
                        begin
                            we    = 1'b1;
                            wa    = wr_idx_reg[AW-1:0];
                            wcode = code_q_reg;
                            wid   = id_q_reg;
                        end
                        wr_idx_next = wr_idx_reg + CW'(1);
                    end
                end
                MODE_CLR_ID:
                begin
                    we = (id_q_reg == op_id_reg);
                end
                MODE_CLR_CODE:
                begin
                    we = (code_q_reg == op_code_reg);
                end
                MODE_FIND_ID:
                begin
                    if (!found_reg && (id_q_reg == op_id_reg))
                    begin
                        answer_next = code_q_reg;
                        found_next  = 1'b1;
                    end
                end
                MODE_FIND_CODE:
                begin
                    if (!found_reg && (code_q_reg == op_code_reg))
                    begin
                        answer_next = {{(CODE_W-ID_W){1'b0}}, id_q_reg};
                        found_next  = 1'b1;
                    end
                end
                MODE_TAIL:
                begin
                    // slots past the compacted run that held a moved entry get emptied
                    we = q_used;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_mode_reg  <= MODE_MOVE;
            found_reg      <= 1'b0;
            dropped_reg    <= 1'b0;
            answer_reg     <= '0;
        end
        else
        begin
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            pipe_valid_reg <= cmd.rd_en;
            pipe_mode_reg  <= cmd.mode;
            found_reg      <= found_next;
            dropped_reg    <= dropped_next;
            answer_reg     <= answer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_code_reg <= key_code;
            op_id_reg   <= binding_id;
        end
        if (cmd.rd_en)
        begin
            pipe_addr_reg <= rd_idx_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            code_mem[wa] <= wcode;
            id_mem[wa]   <= wid;
        end
        if (cmd.rd_en)
        begin
            code_q_reg <= code_mem[rd_idx_reg[AW-1:0]];
            id_q_reg   <= id_mem[rd_idx_reg[AW-1:0]];
        end
    end

    assign status.rd_last = (rd_idx_reg == LAST_IDX);
    assign status.wr_full = (wr_idx_reg == FULL_IDX);
    assign status.wr_last = (wr_idx_reg == LAST_IDX);

    assign answer  = answer_reg;
    assign dropped = dropped_reg;

endmodule

// ===== design/compacting_binding_table.sv =====
// Top level of the compacting binding table: sequencer plus table datapath.
// Adds, clears and lookups sweep the table one entry per cycle on one memory port.
// N = TABLE_ENTRIES. Unused action codes do no table work and return a zero result.
// Add: when the pair lands at p < N-1, a tail pass then empties slots past p.
// One transaction at a time; busy stays high until the result strobe, receiver cannot stall.
// After reset busy is high while a clearing pass empties every entry.
module compacting_binding_table
#(
    parameter int TABLE_ENTRIES = cbt_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cbt_pkg::ACT_W-1:0]         action,
    input  logic signed [cbt_pkg::CODE_W-1:0] key_code,
    input  logic [cbt_pkg::ID_W-1:0]          binding_id,
    output logic                              done,
    output logic signed [cbt_pkg::CODE_W-1:0] answer,
    output logic                              dropped
);
    import cbt_pkg::*;

    cmd_t    cmd;
    status_t status;

    cbt_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cbt_datapath
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key_code   (key_code),
        .binding_id (binding_id),
        .status     (status),
        .answer     (answer),
        .dropped    (dropped)
    );

endmodule

// ===== dv/compacting_binding_table_tb.sv =====
// Testbench for the compacting binding table: random and directed commands checked against a mirror.
module compacting_binding_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbt_pkg::*;

    localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 4 * N_ENTRIES;
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = ACT_ID_OF_CODE + 3'd1;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST = '1;
    localparam logic [CODE_W-1:0] CODE_MAX = 16'h7FFF;
    localparam logic [ID_W-1:0] ID_MAX = '1;

    typedef struct {
        logic [ACT_W-1:0]  op;
        logic [CODE_W-1:0] code;
        logic [ID_W-1:0]   id;
        int                gap_pct;
        bit                drain_first;
    } binding_cmd_t;

    typedef struct {
        logic signed [CODE_W-1:0] answer;
        logic                     dropped;
    } binding_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [ACT_W-1:0]         action = '0;
    logic signed [CODE_W-1:0] key_code = '0;
    logic [ID_W-1:0]          binding_id = '0;
    logic                     done;
    logic signed [CODE_W-1:0] answer;
    logic                     dropped;

    binding_cmd_t    cmd_queue[$];
    binding_result_t answers_due[$];
    logic [CODE_W-1:0] mirror_code[N_ENTRIES];
    logic [ID_W-1:0]   mirror_id[N_ENTRIES];
    int in_flight = 0;
    int n_errors = 0;
    int n_queued = 0;
    int idle_cycles = 0;

    compacting_binding_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .key_code   (key_code),
        .binding_id (binding_id),
        .done       (done),
        .answer     (answer),
        .dropped    (dropped)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Applies one command to the mirror table and returns what the block must answer
    function automatic binding_result_t predict_binding_op(logic [ACT_W-1:0] op,
                                                           logic [CODE_W-1:0] code,
                                                           logic [ID_W-1:0] id);
        binding_result_t r;
        int wr;
        r.answer = '0;
        r.dropped = 1'b0;
        case (op)
            ACT_ADD:
            begin
                wr = 0;
                for (int rd = 0; rd < N_ENTRIES; rd++)
                begin
                    if (mirror_code[rd] != EMPTY_CODE)
                    begin
                        if (wr != rd)
                        begin
                            mirror_code[wr] = mirror_code[rd];
                            mirror_id[wr] = mirror_id[rd];
                            mirror_code[rd] = EMPTY_CODE;
                            mirror_id[rd] = '0;
                        end
                        wr++;
                    end
                end
                if (wr < N_ENTRIES)
                begin
                    mirror_code[wr] = code;
                    mirror_id[wr] = id;
                end
                else
                    r.dropped = 1'b1;
            end
            ACT_CLR_ID, ACT_CLR_CODE:
            begin
                for (int i = 0; i < N_ENTRIES; i++)
                begin
                    if ((op == ACT_CLR_ID) ? (mirror_id[i] == id) : (mirror_code[i] == code))
                    begin
                        mirror_code[i] = EMPTY_CODE;
                        mirror_id[i] = '0;
                    end
                end
            end
            ACT_CODE_OF_ID:
            begin
                r.answer = EMPTY_CODE;
                for (int i = 0; i < N_ENTRIES; i++)
                begin
                    if (mirror_id[i] == id)
                    begin
                        r.answer = mirror_code[i];
                        break;
                    end
                end
            end
            ACT_ID_OF_CODE:
            begin
                r.answer = EMPTY_CODE;
                for (int i = 0; i < N_ENTRIES; i++)
                begin
                    if (mirror_code[i] == code)
                    begin
                        r.answer = {{(CODE_W-ID_W){1'b0}}, mirror_id[i]};
                        break;
                    end
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Idle behavior cycles through phases: none, heavy, none, light
    task automatic push_cmd(input logic [ACT_W-1:0] op, input logic [CODE_W-1:0] code,
                            input logic [ID_W-1:0] id);
        binding_cmd_t c;
        int phase;
        phase = (n_queued / 60) % 4;
        c.op = op;
        c.code = code;
        c.id = id;
        c.gap_pct = (phase == 1) ? 73 : (phase == 3) ? 17 : 0;
        c.drain_first = (n_queued % 150) == 149;
        cmd_queue.push_back(c);
        n_queued++;
    endtask

    // Small pools make lookups and clears hit; the rest spreads over codes 0..CODE_MAX and all ids
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return EMPTY_CODE;
        if (r < 55)
            return CODE_W'($urandom_range(0, 15));
        if (r < 60)
            return (r < 58) ? CODE_MAX : '0;
        return CODE_W'($urandom_range(0, 32767));
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return ID_W'($urandom_range(0, 7));
        if (r < 55)
            return ID_MAX;
        return ID_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ACT_W-1:0] pick_op(int add_pct);
        int r;
        if ($urandom_range(0, 99) < add_pct)
            return ACT_ADD;
        r = $urandom_range(0, 99);
        if (r < 22)
            return ACT_CLR_ID;
        if (r < 44)
            return ACT_CLR_CODE;
        if (r < 70)
            return ACT_CODE_OF_ID;
        if (r < 94)
            return ACT_ID_OF_CODE;
        return ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    endfunction

    // Driver: presents queued commands, predicts each transaction as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        binding_cmd_t nxt;
        bit take;
        bit present;
        if (!rst_n)
        begin
            start <= 1'b0;
            in_flight <= 0;
        end
        else
        begin
            take = start && !busy;
            present = 1'b0;
            if (take)
                answers_due.push_back(predict_binding_op(action, key_code, binding_id));
            in_flight <= in_flight + int'(take) - int'(done);
            if (!start || take)
            begin
                if (cmd_queue.size() != 0)
                begin
                    nxt = cmd_queue[0];
                    if (nxt.drain_first && (take || (in_flight - int'(done)) != 0))
                        present = 1'b0;
                    else
                        present = $urandom_range(0, 99) >= nxt.gap_pct;
                end
                if (present)
                begin
                    void'(cmd_queue.pop_front());
                    action <= nxt.op;
                    key_code <= nxt.code;
                    binding_id <= nxt.id;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        binding_result_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result with nothing expected: answer %0d dropped %0b", answer, dropped);
                n_errors++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (answer !== want.answer)
                begin
                    $error("answer mismatch: expected %0d, actual %0d", want.answer, answer);
                    n_errors++;
                end
                if (dropped !== want.dropped)
                begin
                    $error("dropped mismatch: expected %0b, actual %0b", want.dropped, dropped);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("compacting_binding_table_tb failed");
            $finish;
        end
    end

    initial
    begin
        int n_random;
        int add_pct;
        int len;
        logic [ACT_W-1:0] op;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            mirror_code[i] = EMPTY_CODE;
            mirror_id[i] = '0;
        end

        // Directed: empty-table lookups, extremes, empty-code adds, spare codes, clears
        push_cmd(ACT_ID_OF_CODE, EMPTY_CODE, '0);
        push_cmd(ACT_CODE_OF_ID, '0, '0);
        push_cmd(ACT_CODE_OF_ID, '0, ID_MAX);
        push_cmd(ACT_ADD, CODE_MAX, ID_MAX);
        push_cmd(ACT_ADD, '0, '0);
        push_cmd(ACT_ADD, EMPTY_CODE, 8'd200);
        push_cmd(ACT_ID_OF_CODE, EMPTY_CODE, '0);
        push_cmd(ACT_ADD, 16'd5, 8'd7);
        push_cmd(ACT_CODE_OF_ID, '0, ID_MAX);
        push_cmd(ACT_ID_OF_CODE, '0, 8'd3);
        push_cmd(ACT_SPARE_FIRST, CODE_MAX, ID_MAX);
        push_cmd(ACT_SPARE_FIRST + 3'd1, 16'd5, 8'd7);
        push_cmd(ACT_SPARE_LAST, EMPTY_CODE, '0);
        push_cmd(ACT_CLR_ID, 16'd9, ID_MAX);
        push_cmd(ACT_ADD, 16'd100, 8'd1);
        push_cmd(ACT_ADD, EMPTY_CODE, 8'd42);
        push_cmd(ACT_ADD, 16'h2AAA, 8'h55);
        push_cmd(ACT_CODE_OF_ID, '0, 8'd42);
        push_cmd(ACT_CLR_CODE, '0, 8'd1);
        push_cmd(ACT_CODE_OF_ID, '0, 8'd1);
        push_cmd(ACT_ID_OF_CODE, 16'd100, '0);
        push_cmd(ACT_CLR_CODE, EMPTY_CODE, '0);
        push_cmd(ACT_CLR_ID, '0, '0);
        push_cmd(ACT_ID_OF_CODE, 16'h2AAA, '0);

        // Random: fill bursts that can overflow the table, mixed stretches, some noise
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(60, 75);
                add_pct = 100;
            end
            else
            begin
                len = 40;
                add_pct = $urandom_range(30, 70);
            end
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    op = ACT_W'($urandom_range(0, ACT_SPARE_LAST));
                    push_cmd(op, CODE_W'($urandom_range(0, 32767)),
                             ID_W'($urandom_range(0, 255)));
                end
                else
                begin
                    op = pick_op(add_pct);
                    push_cmd(op, pick_code(), pick_id());
                end
                if (op <= ACT_ID_OF_CODE)
                    n_random++;
            end
        end

        while (cmd_queue.size() != 0 || start)
            @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (answers_due.size() != 0)
        begin
            $error("%0d expected results never arrived", answers_due.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("compacting_binding_table_tb passed");
        else
            $display("compacting_binding_table_tb failed");
        $finish;
    end

endmodule
